>>> src/edge_detect_3x3_stream_assert.svh
// ----------------------------------------------------------------------------
// edge detector assertion macros
// shared assertion forms for the edge detector top level
// ----------------------------------------------------------------------------
`ifndef EDGE_DETECT_3X3_STREAM_ASSERT_SVH
`define EDGE_DETECT_3X3_STREAM_ASSERT_SVH

// condition must never hold while out of reset
`define EDS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define EDS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// types, register indexes, operator codes and kernel tables of the edge detector
// ----------------------------------------------------------------------------
package eds_pkg;

  // input request payload
  typedef struct packed {
    logic [7:0] pixel_value;
    logic       drain;
  } pix_in_t;

  // result payload
  typedef struct packed {
    logic [7:0]  edge_value;
    logic [15:0] out_row;
    logic [10:0] out_col;
    logic        frame_last;
  } pix_out_t;

  // configuration registers as seen by the back end
  typedef struct packed {
    logic [11:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  edge_operator;
  } cfg_t;

  // register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_EDGE_OPERATOR = 2'd2;

  // operator codes
  localparam logic [1:0] OP_ROBERTS   = 2'd0;
  localparam logic [1:0] OP_SOBEL     = 2'd1;
  localparam logic [1:0] OP_PREWITT   = 2'd2;
  localparam logic [1:0] OP_LAPLACIAN = 2'd3;

  // reset values of the registers
  localparam logic [11:0] RST_IMAGE_WIDTH   = 12'd640;
  localparam logic [15:0] RST_IMAGE_HEIGHT  = 16'd480;
  localparam logic [1:0]  RST_EDGE_OPERATOR = OP_SOBEL;

  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [7:0]  PIX_MAX = 8'd255;

  // kernels per operator, window order top-left .. bottom-right
  localparam logic signed [4:0] KER_X [4][9] = '{
    '{-5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0},
    '{-5'sd1, -5'sd2, -5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd2, 5'sd1},
    '{-5'sd1, -5'sd1, -5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd1, 5'sd1},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1}
  };
  localparam logic signed [4:0] KER_Y [4][9] = '{
    '{5'sd0, 5'sd0, -5'sd1, 5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0},
    '{5'sd1, 5'sd0, -5'sd1, 5'sd2, 5'sd0, -5'sd2, 5'sd1, 5'sd0, -5'sd1},
    '{5'sd1, 5'sd0, -5'sd1, 5'sd1, 5'sd0, -5'sd1, 5'sd1, 5'sd0, -5'sd1},
    '{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0}
  };

endpackage

>>> src/eds_ram.sv
// ----------------------------------------------------------------------------
// eds_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module eds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/eds_fifo.sv
// ----------------------------------------------------------------------------
// eds_fifo
// two-entry request queue that decouples producer and consumer
// ----------------------------------------------------------------------------
module eds_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= din;
    end
  end

endmodule

>>> src/eds_front.sv
// ----------------------------------------------------------------------------
// eds_front
// accepts input requests, turns drain requests into zero pixels and queues them
// ----------------------------------------------------------------------------
module eds_front
  import eds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pix_in_t    item,
  output logic       full,
  input  logic       take,
  output logic       px_valid,
  output logic [7:0] px
);

  logic [7:0] px_cls;
  logic       q_empty;

  // a drain request carries a zero pixel
  assign px_cls   = item.drain ? 8'd0 : item.pixel_value;
  assign px_valid = !q_empty;

  eds_fifo #(.WIDTH(8)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (px_cls),
    .full  (full),
    .pop   (take),
    .dout  (px),
    .empty (q_empty)
  );

endmodule

>>> src/eds_back.sv
// ----------------------------------------------------------------------------
// eds_back
// per-pixel sequencer: line stores, window, kernel sums and square root
// ----------------------------------------------------------------------------
module eds_back
  import eds_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       px_valid,
  input  logic [7:0] px,
  output logic       px_take,
  output logic       res_valid,
  output pix_out_t   res,
  input  logic       res_ready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int PW  = WW + 16;
  localparam int CMW = (PW > 27) ? PW : 27;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_MAC  = 7'b0000100,
    S_SQ   = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] col_cnt;
  logic [16:0]   row_cnt;
  logic [26:0]   out_pos;
  logic [7:0]    win [9];
  logic [7:0]    cw [9];
  logic [7:0]    px_r;
  logic signed [13:0] acc_x, acc_y;
  logic [20:0]   sqx, sqy;
  logic [PW-1:0] area;
  logic [15:0]   sval;
  logic [7:0]    root;
  logic [2:0]    bit_idx;
  logic [15:0]   pr;
  logic [10:0]   pc;
  logic          emit_r;
  logic          last_r;

  logic [7:0]    top_raw, mid_raw;
  logic [WW-1:0] iw_ext, w_eff;
  logic [15:0]   h_eff;
  logic [7:0]    t_new, m_new, b_new;
  logic          c_zero;
  logic [WW-1:0] c_ext;
  logic          wr_en;
  logic [21:0]   s_sum;
  logic [7:0]    cand;
  logic [15:0]   cand_sq;
  logic [26:0]   pos1;
  logic signed [13:0] sum_x, sum_y;

  // effective frame size
  always_comb begin
    iw_ext = WW'(cfg.image_width);
    if (cfg.image_width == 12'd0)       w_eff = WW'(1);
    else if (iw_ext > WW'(MAX_WIDTH))   w_eff = WW'(MAX_WIDTH);
    else                                w_eff = iw_ext;
    h_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
  end

  assign px_take = (state == S_IDLE) && px_valid;
  assign wr_en   = (state == S_RD);
  assign c_zero  = (col_cnt == '0);
  assign c_ext   = WW'(col_cnt);

  // two rows back and one row back, by column
  eds_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (col_cnt),
    .wdata (mid_raw),
    .re    (px_take),
    .raddr (col_cnt),
    .rdata (top_raw)
  );

  eds_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (col_cnt),
    .wdata (px_r),
    .re    (px_take),
    .raddr (col_cnt),
    .rdata (mid_raw)
  );

  // new window column, rows outside the image read as zero
  always_comb begin
    t_new = (row_cnt >= 17'd2 && (row_cnt - 17'd2) < {1'b0, h_eff}) ? top_raw : 8'd0;
    m_new = (row_cnt >= 17'd1 && (row_cnt - 17'd1) < {1'b0, h_eff}) ? mid_raw : 8'd0;
    b_new = (row_cnt < {1'b0, h_eff}) ? px_r : 8'd0;
  end

  // kernel sums over the compute window
  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int k = 0; k < 9; k++) begin
      sum_x = sum_x + 14'(KER_X[cfg.edge_operator][k] * $signed({1'b0, cw[k]}));
      sum_y = sum_y + 14'(KER_Y[cfg.edge_operator][k] * $signed({1'b0, cw[k]}));
    end
  end

  assign s_sum   = {1'b0, sqx} + {1'b0, sqy};
  assign cand    = root | (8'd1 << bit_idx);
  assign cand_sq = 16'(cand * cand);
  assign pos1    = out_pos + 27'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (px_valid) state_next = S_RD;
      end
      S_RD:  state_next = S_MAC;
      S_MAC: state_next = S_SQ;
      S_SQ:  state_next = S_SUM;
      S_SUM: begin
        if (cfg.edge_operator == OP_LAPLACIAN || s_sum >= 22'd65536) state_next = S_OUT;
        else state_next = S_ROOT;
      end
      S_ROOT: begin
        if (bit_idx == 3'd0) state_next = S_OUT;
      end
      S_OUT: begin
        if (!emit_r || res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      col_cnt <= '0;
      row_cnt <= '0;
      out_pos <= '0;
      for (int k = 0; k < 9; k++) win[k] <= 8'd0;
    end else begin
      state <= state_next;
      if (state == S_RD) begin
        // window update: a new row restarts the window from the new column
        for (int i = 0; i < 3; i++) begin
          win[i*3]   <= c_zero ? 8'd0 : win[i*3+1];
          win[i*3+1] <= c_zero ? 8'd0 : win[i*3+2];
        end
        win[2] <= t_new;
        win[5] <= m_new;
        win[8] <= b_new;
        // input position
        if (c_ext + WW'(1) >= w_eff) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + 17'd1;
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      if (state == S_SQ && emit_r) begin
        // frame end check
        if (CMW'(pos1) >= CMW'(area)) begin
          col_cnt <= '0;
          row_cnt <= '0;
          out_pos <= '0;
        end else begin
          out_pos <= pos1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (px_valid) px_r <= px;
      end
      S_RD: begin
        for (int i = 0; i < 3; i++) begin
          cw[i*3]   <= win[i*3+1];
          cw[i*3+1] <= win[i*3+2];
        end
        cw[2]  <= c_zero ? 8'd0 : t_new;
        cw[5]  <= c_zero ? 8'd0 : m_new;
        cw[8]  <= c_zero ? 8'd0 : b_new;
        emit_r <= (row_cnt >= 17'd2) || (row_cnt == 17'd1 && !c_zero);
        pr     <= c_zero ? 16'(row_cnt - 17'd2) : 16'(row_cnt - 17'd1);
        pc     <= c_zero ? 11'(w_eff - WW'(1)) : 11'(c_ext - WW'(1));
      end
      S_MAC: begin
        acc_x <= sum_x;
        acc_y <= sum_y;
        area  <= PW'(w_eff * h_eff);
      end
      S_SQ: begin
        sqx    <= 21'(acc_x * acc_x);
        sqy    <= 21'(acc_y * acc_y);
        last_r <= (CMW'(pos1) >= CMW'(area));
      end
      S_SUM: begin
        if (cfg.edge_operator == OP_LAPLACIAN) begin
          if (acc_x < 0)                 root <= 8'd0;
          else if (acc_x > 14'sd255)     root <= PIX_MAX;
          else                           root <= acc_x[7:0];
        end else if (s_sum >= 22'd65536) begin
          root <= PIX_MAX;
        end else begin
          sval    <= s_sum[15:0];
          root    <= 8'd0;
          bit_idx <= 3'd7;
        end
      end
      S_ROOT: begin
        // one result bit per cycle
        if (cand_sq <= sval) root <= cand;
        bit_idx <= bit_idx - 3'd1;
      end
      default: begin
      end
    endcase
  end

  // result
  assign res_valid       = (state == S_OUT) && emit_r;
  assign res.edge_value  = root;
  assign res.out_row     = pr;
  assign res.out_col     = pc;
  assign res.frame_last  = last_r;

endmodule

>>> src/edge_detect_3x3_stream.sv
// ----------------------------------------------------------------------------
// edge_detect_3x3_stream
// 3x3 edge detector over a raster-order grayscale pixel stream
// ----------------------------------------------------------------------------
// Input channel: push/full. A request carries one pixel in raster order, or a
// drain marker; after each frame send image_width+1 drain requests.
// Result channel: empty/pop. The oldest result sits on result while empty is
// low and leaves at an edge with pop high. Each result carries the edge value,
// its row and column, and frame_last on the final pixel of the frame.
// Config: cfg_we/cfg_index/cfg_data write one of image_width, image_height and
// edge_operator, chosen by cfg_index; write only while the block is idle.
// Latency: output lags input by one row plus one pixel of the stream.
// Sequence: the back sequencer handles one request at a time, by line store
// read, kernel sum, squaring and an 8-step root; the root is skipped for the
// laplacian or a sum of squares of 65536 and above.
// Two-entry queues on both sides let the input fill while a result waits.
// Reset clears counters, window and queues; line stores hold no reset value.
// A stalled receiver fills the result queue and then stops the sequencer,
// after which full rises once the input queue holds two requests.
// ----------------------------------------------------------------------------
module edge_detect_3x3_stream
  import eds_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pix_in_t               item,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output pix_out_t              result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "edge_detect_3x3_stream_assert.svh"

  cfg_t       cfg;
  logic       px_valid;
  logic [7:0] px;
  logic       px_take;
  logic       res_valid;
  pix_out_t   res;
  logic       res_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= RST_IMAGE_WIDTH;
      cfg.image_height  <= RST_IMAGE_HEIGHT;
      cfg.edge_operator <= RST_EDGE_OPERATOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[11:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data[15:0];
        REG_EDGE_OPERATOR: cfg.edge_operator <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  eds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .take     (px_take),
    .px_valid (px_valid),
    .px       (px)
  );

  eds_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .px_valid  (px_valid),
    .px        (px),
    .px_take   (px_take),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (!res_full)
  );

  // result queue
  eds_fifo #(.WIDTH($bits(pix_out_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

  // sequencer must only take queued pixels and only deliver into free slots
  `EDS_ASSERT_IMPLY(a_take_has_pixel, clk, rst, px_take, px_valid, "take from empty queue")
  `EDS_ASSERT_NEVER(a_res_no_overflow, clk, rst, res_valid && res_full && px_take, "result lost")

endmodule
